[sv/tots_pkg.sv]
// Shared types and constants for the track odometry and tilt qualifier.
// Holds the register map, the configuration struct and the queue entry.
// No dependencies.
package tots_pkg;

   // Configuration port geometry
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_CLICK_SCALE_LEFT  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_CLICK_SCALE_RIGHT = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_TILT_OFFSET       = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_TILT_SCALE        = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_MIN_TILT          = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_MAX_TILT          = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_MAX_TILT_STEP     = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_RAW_ENABLE        = 3'd7;

   // Field widths
   localparam int CLICK_W  = 16;
   localparam int SCALE_W  = 20;
   localparam int DPROD_W  = CLICK_W + SCALE_W + 1;  // signed click x unsigned scale
   localparam int TRACK_W  = 48;
   localparam int RAW_W    = 32;
   localparam int ANGLE_W  = 24;
   localparam int TSCALE_W = 24;
   localparam int TDIFF_W  = CLICK_W + 1;
   localparam int TPROD_W  = TDIFF_W + TSCALE_W + 1;
   localparam int DIR_W    = 2;

   // Opcodes
   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_CLEAR  = 1'b1;

   // Direction codes
   localparam logic [DIR_W-1:0] DIR_STILL = 2'b00;
   localparam logic [DIR_W-1:0] DIR_UP    = 2'b01;
   localparam logic [DIR_W-1:0] DIR_DOWN  = 2'b11;

   // Dead band, 0.5 degree in 1/256 degree units
   localparam logic [ANGLE_W:0] DEAD_BAND = 25'd128;

   // Rounding half step before the divide by 256
   localparam logic signed [TPROD_W-1:0] ROUND_HALF = 42'sd128;

   // Angle saturation bounds
   localparam logic signed [ANGLE_W-1:0] ANGLE_MAX = 24'sh7FFFFF;
   localparam logic signed [ANGLE_W-1:0] ANGLE_MIN = 24'sh800000;

   typedef struct packed {
      logic [SCALE_W-1:0]         click_scale_left;
      logic [SCALE_W-1:0]         click_scale_right;
      logic signed [CLICK_W-1:0]  tilt_offset;
      logic [TSCALE_W-1:0]        tilt_scale;
      logic signed [ANGLE_W-1:0]  min_tilt;
      logic signed [ANGLE_W-1:0]  max_tilt;
      logic [ANGLE_W-1:0]         max_tilt_step;
      logic                       raw_enable;
   } cfg_type;

   // One classified item between front and back
   typedef struct packed {
      logic                       opcode;
      logic signed [CLICK_W-1:0]  left_clicks;
      logic signed [CLICK_W-1:0]  right_clicks;
      logic signed [DPROD_W-1:0]  dist_left;
      logic signed [DPROD_W-1:0]  dist_right;
      logic signed [ANGLE_W-1:0]  angle;
   } entry_type;

endpackage

[sv/tots_if.sv]
// Valid/ready channel interfaces for sample requests and results.
// Depends on tots_pkg for field widths.
interface tots_req_if;
   import tots_pkg::*;
   logic                      valid;
   logic                      ready;
   logic                      opcode;
   logic signed [CLICK_W-1:0] left_clicks;
   logic signed [CLICK_W-1:0] right_clicks;
   logic signed [CLICK_W-1:0] tilt_raw;

   modport source (output valid, output opcode, output left_clicks, output right_clicks,
                   output tilt_raw, input ready);
   modport sink   (input valid, input opcode, input left_clicks, input right_clicks,
                   input tilt_raw, output ready);
endinterface

interface tots_rsp_if;
   import tots_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [TRACK_W-1:0] odo_left;
   logic signed [TRACK_W-1:0] odo_right;
   logic signed [RAW_W-1:0]   raw_left;
   logic signed [RAW_W-1:0]   raw_right;
   logic                      raw_valid;
   logic signed [ANGLE_W-1:0] arm_tilt;
   logic                      tilt_good;
   logic signed [DIR_W-1:0]   tilt_direction;

   modport source (output valid, output odo_left, output odo_right, output raw_left,
                   output raw_right, output raw_valid, output arm_tilt, output tilt_good,
                   output tilt_direction, input ready);
   modport sink   (input valid, input odo_left, input odo_right, input raw_left,
                   input raw_right, input raw_valid, input arm_tilt, input tilt_good,
                   input tilt_direction, output ready);
endinterface

[sv/track_odometry_and_tilt_qualifier.sv]
// Track odometry and arm tilt qualifier, top level.
// A result passes through the product register, the queue memory and the back end's
// output register; a full queue or a stalled receiver can hold it on the way.
// Throughput: one item per cycle unless the receiver stalls; the back end sets it.
// Reset: synchronous; clears sums, tilt state, queue and valids, and loads
// register defaults. Depends on tots_pkg, tots_if, tots_front, tots_fifo, tots_back.
module track_odometry_and_tilt_qualifier
   import tots_pkg::*;
#(
   parameter int FIFO_DEPTH = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   tots_req_if.sink                req_chan,
   tots_rsp_if.source              rsp_chan,
   input  logic                    csr_wr_en,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata
);

   cfg_type   cfg_ff;
   logic      q_push, q_full, q_pop, q_nonempty;
   entry_type q_data, q_head;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.click_scale_left  <= '0;
         cfg_ff.click_scale_right <= '0;
         cfg_ff.tilt_offset       <= '0;
         cfg_ff.tilt_scale        <= 24'd256;
         cfg_ff.min_tilt          <= ANGLE_MIN;
         cfg_ff.max_tilt          <= ANGLE_MAX;
         cfg_ff.max_tilt_step     <= '1;
         cfg_ff.raw_enable        <= 1'b1;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_CLICK_SCALE_LEFT:  cfg_ff.click_scale_left  <= csr_wdata[SCALE_W-1:0];
            REG_CLICK_SCALE_RIGHT: cfg_ff.click_scale_right <= csr_wdata[SCALE_W-1:0];
            REG_TILT_OFFSET:       cfg_ff.tilt_offset       <= $signed(csr_wdata[CLICK_W-1:0]);
            REG_TILT_SCALE:        cfg_ff.tilt_scale        <= csr_wdata[TSCALE_W-1:0];
            REG_MIN_TILT:          cfg_ff.min_tilt          <= $signed(csr_wdata[ANGLE_W-1:0]);
            REG_MAX_TILT:          cfg_ff.max_tilt          <= $signed(csr_wdata[ANGLE_W-1:0]);
            REG_MAX_TILT_STEP:     cfg_ff.max_tilt_step     <= csr_wdata[ANGLE_W-1:0];
            REG_RAW_ENABLE:        cfg_ff.raw_enable        <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   tots_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .cfg      (cfg_ff),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_data   (q_data)
   );

   tots_fifo #(
      .DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_data),
      .full      (q_full),
      .pop       (q_pop),
      .nonempty  (q_nonempty),
      .head      (q_head)
   );

   tots_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_nonempty (q_nonempty),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .rsp_chan   (rsp_chan)
   );

endmodule

[sv/tots_front.sv]
// Front end: accepts request transfers, forms the scaled products and the
// rounded, saturated tilt angle, and pushes one entry per item into the queue.
// Depends on tots_pkg and tots_req_if.
module tots_front
   import tots_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   tots_req_if.sink   req_chan,
   input  cfg_type    cfg,
   input  logic       q_full,
   output logic       q_push,
   output entry_type  q_data
);

   logic                      valid_ff, valid_in;
   logic                      opcode_ff;
   logic signed [CLICK_W-1:0] lc_ff, rc_ff;
   logic signed [DPROD_W-1:0] pl_ff, pr_ff, pl_in, pr_in;
   logic signed [TPROD_W-1:0] pt_ff, pt_in;
   logic signed [TDIFF_W-1:0] tdiff;
   logic signed [SCALE_W:0]   scl_l, scl_r;
   logic signed [TSCALE_W:0]  scl_t;
   logic signed [TPROD_W-1:0] rounded;
   logic signed [TPROD_W-9:0] shifted;
   logic signed [ANGLE_W-1:0] angle;
   logic                      accept;

   // Stage register frees up when its entry moves into the queue
   assign q_push         = valid_ff && !q_full;
   assign req_chan.ready = !valid_ff || !q_full;
   assign accept         = req_chan.valid && req_chan.ready;

   // Multiplies, one per field
   assign scl_l = $signed({1'b0, cfg.click_scale_left});
   assign scl_r = $signed({1'b0, cfg.click_scale_right});
   assign scl_t = $signed({1'b0, cfg.tilt_scale});
   assign tdiff = TDIFF_W'(req_chan.tilt_raw) - TDIFF_W'(cfg.tilt_offset);
   assign pl_in = DPROD_W'(req_chan.left_clicks) * DPROD_W'(scl_l);
   assign pr_in = DPROD_W'(req_chan.right_clicks) * DPROD_W'(scl_r);
   assign pt_in = TPROD_W'(tdiff) * TPROD_W'(scl_t);

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (q_push) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         opcode_ff <= req_chan.opcode;
         lc_ff     <= req_chan.left_clicks;
         rc_ff     <= req_chan.right_clicks;
         pl_ff     <= pl_in;
         pr_ff     <= pr_in;
         pt_ff     <= pt_in;
      end
   end

   // Round to nearest 1/256 degree (halves up), then saturate to 24 bits
   assign rounded = pt_ff + ROUND_HALF;
   assign shifted = rounded[TPROD_W-1:8];

   always_comb begin
      if (shifted > (TPROD_W-8)'(ANGLE_MAX)) begin
         angle = ANGLE_MAX;
      end else if (shifted < (TPROD_W-8)'(ANGLE_MIN)) begin
         angle = ANGLE_MIN;
      end else begin
         angle = shifted[ANGLE_W-1:0];
      end
   end

   always_comb begin
      q_data.opcode       = opcode_ff;
      q_data.left_clicks  = lc_ff;
      q_data.right_clicks = rc_ff;
      q_data.dist_left    = pl_ff;
      q_data.dist_right   = pr_ff;
      q_data.angle        = angle;
   end

endmodule

[sv/tots_fifo.sv]
// Short queue of classified items between front and back ends.
// Depends on tots_pkg for the entry type.
module tots_fifo
   import tots_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  entry_type  push_data,
   output logic       full,
   input  logic       pop,
   output logic       nonempty,
   output entry_type  head
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type            mem_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]     count_ff;

   assign full     = count_ff == CNT_W'(DEPTH);
   assign nonempty = count_ff != '0;
   assign head     = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   // Pointers wrap at DEPTH so any depth works
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

endmodule

[sv/tots_back.sv]
// Back end: applies queued items to the odometry sums and tilt state, and
// holds each result in an output register until the rsp transfer.
// Depends on tots_pkg and tots_rsp_if.
module tots_back
   import tots_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       q_nonempty,
   input  entry_type  q_head,
   output logic       q_pop,
   tots_rsp_if.source rsp_chan
);

   // Running state
   logic [TRACK_W-1:0]        dl_ff, dl_in, dr_ff, dr_in;
   logic [RAW_W-1:0]          rl_ff, rl_in, rr_ff, rr_in;
   logic signed [ANGLE_W-1:0] last_ff, last_in;
   logic [DIR_W-1:0]          sign_ff, sign_in;

   // Output register
   logic                      out_valid_ff, out_valid_in;
   logic [TRACK_W-1:0]        o_tl_ff, o_tr_ff;
   logic [RAW_W-1:0]          o_rl_ff, o_rr_ff;
   logic                      o_rv_ff, o_good_ff, good;

   logic signed [ANGLE_W:0]   d;
   logic [ANGLE_W:0]          ad;
   logic                      in_range;

   assign q_pop = q_nonempty && (!out_valid_ff || rsp_chan.ready);

   // Tilt difference against the last good angle
   assign d        = {q_head.angle[ANGLE_W-1], q_head.angle} - {last_ff[ANGLE_W-1], last_ff};
   assign ad       = d[ANGLE_W] ? 25'(-d) : 25'(d);
   assign in_range = (q_head.angle > cfg.min_tilt) && (q_head.angle < cfg.max_tilt)
                     && (ad < {1'b0, cfg.max_tilt_step});

   // Next state for one item
   always_comb begin
      dl_in   = dl_ff;
      dr_in   = dr_ff;
      rl_in   = rl_ff;
      rr_in   = rr_ff;
      last_in = last_ff;
      sign_in = sign_ff;
      good    = 1'b0;
      if (q_head.opcode == OP_CLEAR) begin
         dl_in = '0;
         dr_in = '0;
         if (cfg.raw_enable) begin
            rl_in = '0;
            rr_in = '0;
         end
      end else begin
         dl_in = dl_ff + {{(TRACK_W-DPROD_W){q_head.dist_left[DPROD_W-1]}}, q_head.dist_left};
         dr_in = dr_ff + {{(TRACK_W-DPROD_W){q_head.dist_right[DPROD_W-1]}},
                          q_head.dist_right};
         if (cfg.raw_enable) begin
            rl_in = rl_ff + {{(RAW_W-CLICK_W){q_head.left_clicks[CLICK_W-1]}},
                             q_head.left_clicks};
            rr_in = rr_ff + {{(RAW_W-CLICK_W){q_head.right_clicks[CLICK_W-1]}},
                             q_head.right_clicks};
         end
         if (in_range) begin
            good    = 1'b1;
            last_in = q_head.angle;
            // dead band; exactly half a degree keeps the old sign
            if (ad < DEAD_BAND) begin
               sign_in = DIR_STILL;
            end else if (d > $signed(DEAD_BAND)) begin
               sign_in = DIR_UP;
            end else if (d < -$signed(DEAD_BAND)) begin
               sign_in = DIR_DOWN;
            end
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (q_pop) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dl_ff        <= '0;
         dr_ff        <= '0;
         rl_ff        <= '0;
         rr_ff        <= '0;
         last_ff      <= '0;
         sign_ff      <= DIR_STILL;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (q_pop) begin
            dl_ff   <= dl_in;
            dr_ff   <= dr_in;
            rl_ff   <= rl_in;
            rr_ff   <= rr_in;
            last_ff <= last_in;
            sign_ff <= sign_in;
         end
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (q_pop) begin
         o_tl_ff   <= dl_in;
         o_tr_ff   <= dr_in;
         o_rl_ff   <= cfg.raw_enable ? rl_in : '0;
         o_rr_ff   <= cfg.raw_enable ? rr_in : '0;
         o_rv_ff   <= cfg.raw_enable;
         o_good_ff <= good;
      end
   end

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.odo_left       = $signed(o_tl_ff);
   assign rsp_chan.odo_right      = $signed(o_tr_ff);
   assign rsp_chan.raw_left       = $signed(o_rl_ff);
   assign rsp_chan.raw_right      = $signed(o_rr_ff);
   assign rsp_chan.raw_valid      = o_rv_ff;
   assign rsp_chan.arm_tilt       = last_ff;
   assign rsp_chan.tilt_good      = o_good_ff;
   assign rsp_chan.tilt_direction = $signed(sign_ff);

endmodule

[verif/tb_track_odometry_and_tilt_qualifier.sv]
// Self-checking bench for the track odometry and arm tilt qualifier.
// Holds a per-transfer predictor of the sums and the tilt filter, plus driver,
// receiver and result checker. Depends on tots_pkg, tots_if and the RTL top.
module tb_track_odometry_and_tilt_qualifier;
   import tots_pkg::*;

   localparam int RESULT_LATENCY = 2;
   localparam int CYCLE_LIMIT    = 400000;
   localparam int LONG_HOLD      = 80;
   localparam int PRINT_CAP      = 50;

   // One request transfer
   typedef struct packed {
      logic                      opcode;
      logic signed [CLICK_W-1:0] left_clicks;
      logic signed [CLICK_W-1:0] right_clicks;
      logic signed [CLICK_W-1:0] tilt_raw;
   } sample_type;

   // One result transfer, as expected
   typedef struct packed {
      logic [TRACK_W-1:0] odo_left;
      logic [TRACK_W-1:0] odo_right;
      logic [RAW_W-1:0]   raw_left;
      logic [RAW_W-1:0]   raw_right;
      logic               raw_valid;
      logic [ANGLE_W-1:0] arm_tilt;
      logic               tilt_good;
      logic [DIR_W-1:0]   tilt_direction;
   } report_type;

   logic                   clock;
   logic                   reset;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   tots_req_if req_chan ();
   tots_rsp_if rsp_chan ();

   track_odometry_and_tilt_qualifier DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Predictor copy of the registers and the odometry/tilt state
   cfg_type                   settings;
   logic [TRACK_W-1:0]        dist_left, dist_right;
   logic [RAW_W-1:0]          clicks_left, clicks_right;
   logic signed [ANGLE_W-1:0] good_angle;
   logic [DIR_W-1:0]          heading;

   sample_type  pending_samples[$];
   report_type  expected_reports[$];

   // Bench bookkeeping
   logic        req_taken;
   int          gap_left = 0, stall_left = 0, hold_left = 0;
   int          send_idle_pct, rcv_idle_pct;
   int          holds_asked, holds_served = 0;
   int          transfers_in = 0, results_checked = 0, mismatches = 0, reg_writes;
   int          tilts_accepted = 0, clears_seen = 0;
   int          cycle_count = 0;
   logic signed [CLICK_W-1:0] tilt_walk;

   // Clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: timeout after %0d cycles", cycle_count);
         $display("tb: failure");
         $finish;
      end
   end

   function automatic int pick_idle();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 80)
         return $urandom_range(1, 3);
      else if (r < 95)
         return $urandom_range(4, 10);
      return $urandom_range(15, 40);
   endfunction

   // Next state and expected result for one accepted item
   function automatic report_type advance_odometry(input sample_type s);
      report_type rep;
      longint     prod, angle, delta, spread;
      rep = '0;
      if (s.opcode == OP_CLEAR) begin
         dist_left  = '0;
         dist_right = '0;
         if (settings.raw_enable) begin
            clicks_left  = '0;
            clicks_right = '0;
         end
      end else begin
         if (settings.raw_enable) begin
            clicks_left  = clicks_left + RAW_W'(longint'(signed'(s.left_clicks)));
            clicks_right = clicks_right + RAW_W'(longint'(signed'(s.right_clicks)));
         end
         dist_left  = dist_left + TRACK_W'(longint'(signed'(s.left_clicks)) *
                                           longint'(settings.click_scale_left));
         dist_right = dist_right + TRACK_W'(longint'(signed'(s.right_clicks)) *
                                            longint'(settings.click_scale_right));

         // fixed-point degrees, round half up, saturate to the angle range
         prod  = (longint'(signed'(s.tilt_raw)) - longint'(signed'(settings.tilt_offset))) *
                 longint'(settings.tilt_scale);
         angle = (prod + longint'(ROUND_HALF)) >>> 8;
         if (angle > longint'(ANGLE_MAX)) angle = longint'(ANGLE_MAX);
         if (angle < longint'(ANGLE_MIN)) angle = longint'(ANGLE_MIN);

         // strict limits and step bound, then the dead band on direction
         delta  = angle - longint'(good_angle);
         spread = (delta < 0) ? -delta : delta;
         if (angle > longint'(signed'(settings.min_tilt)) &&
             angle < longint'(signed'(settings.max_tilt)) &&
             spread < longint'(settings.max_tilt_step)) begin
            rep.tilt_good = 1'b1;
            if (spread < longint'(DEAD_BAND))
               heading = DIR_STILL;
            else if (delta > longint'(DEAD_BAND))
               heading = DIR_UP;
            else if (delta < -longint'(DEAD_BAND))
               heading = DIR_DOWN;
            good_angle = ANGLE_W'(angle);
         end
      end
      rep.odo_left       = dist_left;
      rep.odo_right      = dist_right;
      rep.raw_left       = settings.raw_enable ? clicks_left : '0;
      rep.raw_right      = settings.raw_enable ? clicks_right : '0;
      rep.raw_valid      = settings.raw_enable;
      rep.arm_tilt       = good_angle;
      rep.tilt_direction = heading;
      return rep;
   endfunction

   task automatic report_mismatch(input string what);
      mismatches++;
      if (mismatches <= PRINT_CAP)
         $display("tb: mismatch at result %0d: %s", results_checked, what);
   endtask

   task automatic check_field(input string name, input logic [TRACK_W-1:0] got,
                              input logic [TRACK_W-1:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %h expected %h", name, got, want));
   endtask

   // Request driver: new offer at the falling edge once the last one transferred
   always @(negedge clock) begin
      sample_type nxt;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (req_chan.valid && !req_taken) begin
         // offer stands until it transfers
      end else if (gap_left > 0) begin
         gap_left--;
         req_chan.valid <= 1'b0;
      end else if (pending_samples.size() != 0) begin
         nxt = pending_samples.pop_front();
         req_chan.valid        <= 1'b1;
         req_chan.opcode       <= nxt.opcode;
         req_chan.left_clicks  <= nxt.left_clicks;
         req_chan.right_clicks <= nxt.right_clicks;
         req_chan.tilt_raw     <= nxt.tilt_raw;
         gap_left = ($urandom_range(0, 99) < send_idle_pct) ? pick_idle() : 0;
      end else begin
         req_chan.valid <= 1'b0;
      end
   end

   // Result receiver: random stalls plus requested long hold-offs
   always @(negedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (holds_served < holds_asked) begin
            holds_served++;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else if ($urandom_range(0, 99) < rcv_idle_pct) begin
            stall_left = pick_idle() - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // Monitor: predict on each request transfer, check each result transfer
   always @(posedge clock) begin
      sample_type taken;
      report_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_chan.valid && req_chan.ready;
         if (req_chan.valid && req_chan.ready) begin
            taken.opcode       = req_chan.opcode;
            taken.left_clicks  = req_chan.left_clicks;
            taken.right_clicks = req_chan.right_clicks;
            taken.tilt_raw     = req_chan.tilt_raw;
            want = advance_odometry(taken);
            expected_reports.push_back(want);
            transfers_in++;
            if (want.tilt_good) tilts_accepted++;
            if (taken.opcode == OP_CLEAR) clears_seen++;
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_reports.size() == 0) begin
               report_mismatch("result with nothing outstanding");
            end else begin
               want = expected_reports.pop_front();
               check_field("odo_left", $unsigned(rsp_chan.odo_left), want.odo_left);
               check_field("odo_right", $unsigned(rsp_chan.odo_right), want.odo_right);
               check_field("raw_left", $unsigned(rsp_chan.raw_left), want.raw_left);
               check_field("raw_right", $unsigned(rsp_chan.raw_right), want.raw_right);
               check_field("raw_valid", rsp_chan.raw_valid, want.raw_valid);
               check_field("arm_tilt", $unsigned(rsp_chan.arm_tilt), want.arm_tilt);
               check_field("tilt_good", rsp_chan.tilt_good, want.tilt_good);
               check_field("tilt_direction", $unsigned(rsp_chan.tilt_direction),
                           want.tilt_direction);
            end
            results_checked++;
         end
      end
   end

   // Register write at the falling edge; predictor copy follows
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         REG_CLICK_SCALE_LEFT:  settings.click_scale_left  = val[SCALE_W-1:0];
         REG_CLICK_SCALE_RIGHT: settings.click_scale_right = val[SCALE_W-1:0];
         REG_TILT_OFFSET:       settings.tilt_offset       = val[CLICK_W-1:0];
         REG_TILT_SCALE:        settings.tilt_scale        = val[TSCALE_W-1:0];
         REG_MIN_TILT:          settings.min_tilt          = val[ANGLE_W-1:0];
         REG_MAX_TILT:          settings.max_tilt          = val[ANGLE_W-1:0];
         REG_MAX_TILT_STEP:     settings.max_tilt_step     = val[ANGLE_W-1:0];
         REG_RAW_ENABLE:        settings.raw_enable        = val[0];
         default: ;
      endcase
      @(negedge clock);
      csr_wr_en <= 1'b0;
      reg_writes++;
   endtask

   task automatic load_settings(input cfg_type c);
      write_reg(REG_CLICK_SCALE_LEFT, CSR_DATA_W'(c.click_scale_left));
      write_reg(REG_CLICK_SCALE_RIGHT, CSR_DATA_W'(c.click_scale_right));
      write_reg(REG_TILT_OFFSET, {8'h00, c.tilt_offset});
      write_reg(REG_TILT_SCALE, c.tilt_scale);
      write_reg(REG_MIN_TILT, c.min_tilt);
      write_reg(REG_MAX_TILT, c.max_tilt);
      write_reg(REG_MAX_TILT_STEP, c.max_tilt_step);
      write_reg(REG_RAW_ENABLE, {23'd0, c.raw_enable});
   endtask

   // Sender waits until every outstanding result has come back
   task automatic drain_results();
      while (pending_samples.size() != 0 || req_chan.valid || expected_reports.size() != 0)
         @(posedge clock);
      repeat (RESULT_LATENCY + 2) @(posedge clock);
   endtask

   task automatic add_sample(input logic signed [CLICK_W-1:0] l,
                             input logic signed [CLICK_W-1:0] r,
                             input logic signed [CLICK_W-1:0] t);
      sample_type s;
      s.opcode       = OP_SAMPLE;
      s.left_clicks  = l;
      s.right_clicks = r;
      s.tilt_raw     = t;
      pending_samples.push_back(s);
   endtask

   task automatic add_clear();
      sample_type s;
      s.opcode       = OP_CLEAR;
      s.left_clicks  = 16'($urandom);
      s.right_clicks = 16'($urandom);
      s.tilt_raw     = 16'($urandom);
      pending_samples.push_back(s);
   endtask

   function automatic logic signed [CLICK_W-1:0] pick_clicks();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 70)
         return 16'($urandom_range(0, 400) - 200);
      else if (r < 90)
         return 16'($urandom);
      case ($urandom_range(0, 3))
         0:       return 16'sh7FFF;
         1:       return 16'sh8000;
         2:       return 16'sh0000;
         default: return 16'shFFFF;
      endcase
   endfunction

   // Random items: mostly samples whose tilt walks in small steps
   task automatic queue_random(input int count);
      sample_type s;
      repeat (count) begin
         s.opcode       = ($urandom_range(0, 99) < 6) ? OP_CLEAR : OP_SAMPLE;
         s.left_clicks  = pick_clicks();
         s.right_clicks = pick_clicks();
         if ($urandom_range(0, 99) < 25)
            tilt_walk = 16'($urandom);
         else
            tilt_walk = tilt_walk + 16'($urandom_range(0, 6)) - 16'd3;
         s.tilt_raw = tilt_walk;
         pending_samples.push_back(s);
      end
   endtask

   function automatic cfg_type roll_settings();
      cfg_type     c;
      int unsigned n;
      c.click_scale_left  = ($urandom_range(0, 9) == 0) ? 20'hFFFFF : 20'($urandom);
      c.click_scale_right = ($urandom_range(0, 9) == 0) ? 20'h00000 : 20'($urandom);
      c.tilt_offset = ($urandom_range(0, 2) == 0) ? 16'($urandom)
                                                   : 16'($urandom_range(0, 1000) - 500);
      case ($urandom_range(0, 9))
         0, 1, 2, 3: c.tilt_scale = 24'd256;
         4, 5:       c.tilt_scale = 24'd128;
         6, 7:       c.tilt_scale = 24'($urandom_range(1, 2048));
         8:          c.tilt_scale = 24'($urandom);
         default:    c.tilt_scale = 24'd0;
      endcase
      n = $urandom_range(256, 200000);
      case ($urandom_range(0, 9))
         0, 1, 2, 3: begin
            c.min_tilt = ANGLE_MIN;
            c.max_tilt = ANGLE_MAX;
         end
         4, 5, 6, 7: begin
            c.min_tilt = 24'(-longint'(n));
            c.max_tilt = 24'(n);
         end
         8: begin
            c.min_tilt = 24'($urandom);
            c.max_tilt = 24'($urandom);
         end
         default: begin
            c.min_tilt = 24'($urandom);
            c.max_tilt = c.min_tilt;
         end
      endcase
      case ($urandom_range(0, 9))
         0, 1, 2, 3: c.max_tilt_step = 24'hFFFFFF;
         4, 5, 6, 7: c.max_tilt_step = 24'($urandom_range(100, 5000));
         8:          c.max_tilt_step = 24'($urandom_range(0, 128));
         default:    c.max_tilt_step = 24'($urandom);
      endcase
      c.raw_enable = 1'($urandom_range(0, 1));
      return c;
   endfunction

   function automatic int pick_pct();
      case ($urandom_range(0, 3))
         0:       return 0;
         1:       return 10;
         2:       return 30;
         default: return 60;
      endcase
   endfunction

   // Stimulus
   initial begin
      cfg_type s;
      reset                 = 1'b1;
      csr_wr_en             = 1'b0;
      csr_index             = '0;
      csr_wdata             = '0;
      send_idle_pct = 0; rcv_idle_pct = 0;
      holds_asked = 0; reg_writes = 0;
      tilt_walk = '0;

      // register defaults and cleared state after reset
      settings.click_scale_left  = '0;
      settings.click_scale_right = '0;
      settings.tilt_offset       = '0;
      settings.tilt_scale        = 24'd256;
      settings.min_tilt          = ANGLE_MIN;
      settings.max_tilt          = ANGLE_MAX;
      settings.max_tilt_step     = 24'hFFFFFF;
      settings.raw_enable        = 1'b1;
      dist_left = '0; dist_right = '0;
      clicks_left = '0; clicks_right = '0;
      good_angle = '0;
      heading = DIR_STILL;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // defaults straight out of reset
      add_sample(16'sd5, -16'sd3, 16'sd40);
      drain_results();

      // click and tilt extremes, clear, dead band edges at +/- half a degree
      s = settings;
      s.click_scale_left  = 20'hFFFFF;
      s.click_scale_right = 20'd1;
      load_settings(s);
      add_sample(16'sh7FFF, 16'sh8000, 16'sh7FFF);
      add_sample(16'sh8000, 16'sh7FFF, 16'sh8000);
      add_clear();
      add_sample(16'sd1, -16'sd1, 16'sd0);
      add_sample(16'sd0, 16'sd0, 16'sd128);
      add_sample(16'sd0, 16'sd0, 16'sd0);
      add_sample(16'sd0, 16'sd0, 16'sd200);
      add_sample(16'sd0, 16'sd0, 16'sd72);
      add_sample(16'sd0, 16'sd0, -16'sd60);
      add_sample(16'sd0, 16'sd0, -16'sd10);
      drain_results();

      // raw sums frozen, step bound and strict limits
      s = settings;
      s.raw_enable    = 1'b0;
      s.min_tilt      = -24'sd300;
      s.max_tilt      = 24'sd300;
      s.max_tilt_step = 24'd100;
      load_settings(s);
      add_sample(16'sd7, 16'sd9, 16'sd90);
      add_sample(16'sd7, 16'sd9, 16'sd89);
      add_sample(16'sd7, 16'sd9, 16'sd180);
      add_sample(16'sd7, 16'sd9, 16'sd260);
      add_sample(16'sd7, 16'sd9, 16'sd300);
      add_sample(16'sd7, 16'sd9, 16'sd299);
      add_clear();
      add_sample(16'sd5, -16'sd5, 16'sd299);
      drain_results();

      // half-step rounding, raw sums back on
      s = settings;
      s.raw_enable        = 1'b1;
      s.click_scale_left  = 20'd0;
      s.click_scale_right = 20'hFFFFF;
      s.tilt_offset       = 16'sd0;
      s.tilt_scale        = 24'd128;
      s.min_tilt          = ANGLE_MIN;
      s.max_tilt          = ANGLE_MAX;
      s.max_tilt_step     = 24'hFFFFFF;
      load_settings(s);
      add_sample(16'sd3, 16'sd3, 16'sd1);
      add_sample(16'sd3, 16'sd3, -16'sd1);
      add_sample(16'sd3, 16'sd3, 16'sd3);
      drain_results();

      // saturated angles at both ends are rejected
      s = settings;
      s.tilt_offset = 16'sh7FFF;
      s.tilt_scale  = 24'hFFFFFF;
      load_settings(s);
      add_sample(16'sd1, 16'sd1, 16'sh8000);
      drain_results();
      s = settings;
      s.tilt_offset = 16'sh8000;
      load_settings(s);
      add_sample(16'sd1, 16'sd1, 16'sh7FFF);
      drain_results();

      // equal limits, zero step, zero scale
      s = settings;
      s.tilt_scale    = 24'd0;
      s.min_tilt      = 24'sd5;
      s.max_tilt      = 24'sd5;
      s.max_tilt_step = 24'd0;
      load_settings(s);
      add_sample(16'sd2, 16'sd2, 16'sd4);
      drain_results();

      // random phases under fresh settings and idling mixes
      for (int phase = 0; phase < 6; phase++) begin
         load_settings(roll_settings());
         tilt_walk = settings.tilt_offset + 16'($urandom_range(0, 40)) - 16'd20;
         if (phase == 0) begin
            // receiver holds off while the sender keeps offering: block backs up
            send_idle_pct = 0;
            rcv_idle_pct  = 10;
            holds_asked++;
         end else begin
            send_idle_pct = pick_pct();
            rcv_idle_pct  = pick_pct();
         end
         if (phase == 2) begin
            queue_random(30);
            drain_results();
            queue_random(30);
         end else begin
            queue_random(60);
         end
         drain_results();

         if (phase == 2) begin
            // back-to-back run of full-scale clicks at the top scale on both tracks
            s = settings;
            s.click_scale_left  = 20'hFFFFF;
            s.click_scale_right = 20'hFFFFF;
            s.raw_enable        = 1'b1;
            load_settings(s);
            send_idle_pct = 0;
            rcv_idle_pct  = 0;
            repeat (16) begin
               tilt_walk = tilt_walk + 16'($urandom_range(0, 2)) - 16'd1;
               add_sample(16'sh7FFF, 16'sh8000, tilt_walk);
            end
            drain_results();
         end
      end

      repeat (RESULT_LATENCY + 8) @(posedge clock);
      $display("tb: %0d transfers in, %0d results checked, %0d register writes",
               transfers_in, results_checked, reg_writes);
      $display("tb: %0d tilts accepted, %0d odometry clears, %0d mismatches, %0d cycles",
               tilts_accepted, clears_seen, mismatches, cycle_count);
      if (mismatches == 0 && expected_reports.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
